### hdl/msc_pkg.sv
// Shared types, constants and helper functions for the mm:ss clock core.
`default_nettype none

package msc_pkg;

  localparam int COUNTER_WIDTH = 16;   // elapsed millisecond counters
  localparam int CFG_W         = 16;   // interval register width
  localparam int LEVEL_W       = 10;   // keypad sample width
  localparam int TVAL_W        = 6;    // minutes / seconds width
  localparam int CFG_IDX_W     = 2;
  localparam int CMP_W         = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

  typedef logic [TVAL_W-1:0]        tval_t;
  typedef logic [COUNTER_WIDTH-1:0] count_t;
  typedef logic [CFG_W-1:0]         interval_t;
  typedef logic [LEVEL_W-1:0]       level_t;

  typedef enum logic [1:0] {
    MODE_RUN = 2'd0,
    MODE_MIN = 2'd1,
    MODE_SEC = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_RIGHT  = 3'd1,
    KEY_UP     = 3'd2,
    KEY_DOWN   = 3'd3,
    KEY_LEFT   = 3'd4,
    KEY_SELECT = 3'd5
  } key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_INTERVAL    = 2'd0,
    CFG_SECOND_INTERVAL = 2'd1
  } cfg_idx_t;

  localparam interval_t KEY_INTERVAL_RST    = 16'd150;
  localparam interval_t SECOND_INTERVAL_RST = 16'd1000;

  localparam tval_t TVAL_MAX = 6'd59;

  // Resistor ladder thresholds
  localparam level_t LEVEL_NONE_ABOVE   = 10'd1000;
  localparam level_t LEVEL_RIGHT_BELOW  = 10'd50;
  localparam level_t LEVEL_UP_BELOW     = 10'd195;
  localparam level_t LEVEL_DOWN_BELOW   = 10'd380;
  localparam level_t LEVEL_LEFT_BELOW   = 10'd555;
  localparam level_t LEVEL_SELECT_BELOW = 10'd790;

  typedef struct packed {
    interval_t key_interval;
    interval_t second_interval;
  } cfg_t;

  typedef struct packed {
    mode_t  mode;
    tval_t  clock_minutes;
    tval_t  clock_seconds;
    tval_t  edit_minutes;
    tval_t  edit_seconds;
    key_t   key_code;
    logic   start_request;
  } result_t;

  function automatic key_t decode_level(input level_t level);
    key_t k;
    if (level > LEVEL_NONE_ABOVE)         k = KEY_NONE;
    else if (level < LEVEL_RIGHT_BELOW)   k = KEY_RIGHT;
    else if (level < LEVEL_UP_BELOW)      k = KEY_UP;
    else if (level < LEVEL_DOWN_BELOW)    k = KEY_DOWN;
    else if (level < LEVEL_LEFT_BELOW)    k = KEY_LEFT;
    else if (level < LEVEL_SELECT_BELOW)  k = KEY_SELECT;
    else                                  k = KEY_NONE;
    return k;
  endfunction

  function automatic tval_t wrap_up(input tval_t v);
    return (v < TVAL_MAX) ? tval_t'(v + 6'd1) : '0;
  endfunction

  function automatic tval_t wrap_down(input tval_t v);
    return ((v != '0) && (v <= TVAL_MAX)) ? tval_t'(v - 6'd1) : TVAL_MAX;
  endfunction

  // Saturating increment
  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : count_t'(v + 1'b1);
  endfunction

  // Counter has reached the interval (zero interval is due every tick)
  function automatic logic interval_due(input count_t cnt, input interval_t iv);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(cnt);
    b = CMP_W'(iv);
    return a >= b;
  endfunction

endpackage

`default_nettype wire

### hdl/msc_if.sv
// Channel interfaces: keypad tick input, result output and register write port.
`default_nettype none

interface msc_in_if;
  logic                    valid;
  logic                    ready;
  logic [msc_pkg::LEVEL_W-1:0] key_level;
  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface msc_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [msc_pkg::TVAL_W-1:0] clock_minutes;
  logic [msc_pkg::TVAL_W-1:0] clock_seconds;
  logic [msc_pkg::TVAL_W-1:0] edit_minutes;
  logic [msc_pkg::TVAL_W-1:0] edit_seconds;
  logic [2:0]                 key_code;
  logic                       start_request;
  modport source (output valid, output mode, output clock_minutes, output clock_seconds,
                  output edit_minutes, output edit_seconds, output key_code,
                  output start_request, input ready);
  modport sink   (input valid, input mode, input clock_minutes, input clock_seconds,
                  input edit_minutes, input edit_seconds, input key_code,
                  input start_request, output ready);
endinterface

interface msc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [msc_pkg::CFG_IDX_W-1:0] index;
  logic [msc_pkg::CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/msc_cfg.sv
// Interval configuration registers.
`default_nettype none

module msc_cfg (
  input  wire logic     clk,
  input  wire logic     rst_n,
  msc_cfg_if.sink       cfg_s,
  output msc_pkg::cfg_t cfg
);

  msc_pkg::interval_t key_iv_r, key_iv_nxt;
  msc_pkg::interval_t sec_iv_r, sec_iv_nxt;
  logic               wr;

  assign cfg_s.ready = 1'b1;
  assign wr          = cfg_s.valid;

  always_comb begin
    key_iv_nxt = key_iv_r;
    sec_iv_nxt = sec_iv_r;
    if (wr) begin
      case (msc_pkg::cfg_idx_t'(cfg_s.index))
        msc_pkg::CFG_KEY_INTERVAL:    key_iv_nxt = cfg_s.data;
        msc_pkg::CFG_SECOND_INTERVAL: sec_iv_nxt = cfg_s.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_iv_r <= msc_pkg::KEY_INTERVAL_RST;
      sec_iv_r <= msc_pkg::SECOND_INTERVAL_RST;
    end else begin
      key_iv_r <= key_iv_nxt;
      sec_iv_r <= sec_iv_nxt;
    end
  end

  assign cfg.key_interval    = key_iv_r;
  assign cfg.second_interval = sec_iv_r;

endmodule

`default_nettype wire

### hdl/msc_engine.sv
// Clock state, key timer and mode logic; one tick processed per step.
`default_nettype none

module msc_engine (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire msc_pkg::level_t  level,
  input  wire msc_pkg::cfg_t    cfg,
  output msc_pkg::result_t      res
);

  msc_pkg::mode_t  mode_r, mode_nxt;
  msc_pkg::tval_t  run_min_r, run_min_nxt;
  msc_pkg::tval_t  run_sec_r, run_sec_nxt;
  msc_pkg::tval_t  set_min_r, set_min_nxt;
  msc_pkg::tval_t  set_sec_r, set_sec_nxt;
  msc_pkg::count_t key_el_r, key_el_nxt;
  msc_pkg::count_t sec_el_r, sec_el_nxt;
  msc_pkg::count_t key_inc;
  msc_pkg::count_t sec_inc;
  msc_pkg::key_t   key;
  logic            start;

  always_comb begin
    // key sampling
    key_inc    = msc_pkg::sat_inc(key_el_r);
    key_el_nxt = key_inc;
    key        = msc_pkg::KEY_NONE;
    if (msc_pkg::interval_due(key_inc, cfg.key_interval)) begin
      key = msc_pkg::decode_level(level);
      if (key != msc_pkg::KEY_NONE) key_el_nxt = '0;
    end

    // mode handling
    mode_nxt    = mode_r;
    run_min_nxt = run_min_r;
    run_sec_nxt = run_sec_r;
    set_min_nxt = set_min_r;
    set_sec_nxt = set_sec_r;
    start       = 1'b0;
    case (mode_r)
      msc_pkg::MODE_MIN: begin
        if (key == msc_pkg::KEY_UP)          set_min_nxt = msc_pkg::wrap_up(set_min_r);
        else if (key == msc_pkg::KEY_DOWN)   set_min_nxt = msc_pkg::wrap_down(set_min_r);
        else if (key == msc_pkg::KEY_RIGHT)  mode_nxt    = msc_pkg::MODE_SEC;
        else if (key == msc_pkg::KEY_SELECT) begin
          mode_nxt    = msc_pkg::MODE_RUN;
          run_min_nxt = set_min_r;
          run_sec_nxt = set_sec_r;
        end
      end
      msc_pkg::MODE_SEC: begin
        if (key == msc_pkg::KEY_UP)          set_sec_nxt = msc_pkg::wrap_up(set_sec_r);
        else if (key == msc_pkg::KEY_DOWN)   set_sec_nxt = msc_pkg::wrap_down(set_sec_r);
        else if (key == msc_pkg::KEY_LEFT)   mode_nxt    = msc_pkg::MODE_MIN;
        else if (key == msc_pkg::KEY_SELECT) begin
          mode_nxt    = msc_pkg::MODE_RUN;
          run_min_nxt = set_min_r;
          run_sec_nxt = set_sec_r;
        end
      end
      default: begin
        mode_nxt = msc_pkg::MODE_RUN;
        if (key == msc_pkg::KEY_SELECT) begin
          mode_nxt    = msc_pkg::MODE_MIN;
          set_min_nxt = run_min_r;
          set_sec_nxt = run_sec_r;
        end else if (key == msc_pkg::KEY_UP) begin
          start = 1'b1;
        end
      end
    endcase

    // second tick, applied after any commit
    sec_inc    = msc_pkg::sat_inc(sec_el_r);
    sec_el_nxt = sec_inc;
    if (msc_pkg::interval_due(sec_inc, cfg.second_interval)) begin
      if (run_sec_nxt < msc_pkg::TVAL_MAX) begin
        run_sec_nxt = msc_pkg::tval_t'(run_sec_nxt + 6'd1);
      end else begin
        run_sec_nxt = '0;
        run_min_nxt = msc_pkg::wrap_up(run_min_nxt);
      end
      sec_el_nxt = '0;
    end

    res.mode          = mode_nxt;
    res.clock_minutes = run_min_nxt;
    res.clock_seconds = run_sec_nxt;
    res.edit_minutes  = set_min_nxt;
    res.edit_seconds  = set_sec_nxt;
    res.key_code      = key;
    res.start_request = start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= msc_pkg::MODE_RUN;
      run_min_r <= '0;
      run_sec_r <= '0;
      set_min_r <= '0;
      set_sec_r <= '0;
      key_el_r  <= '0;
      sec_el_r  <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      run_min_r <= run_min_nxt;
      run_sec_r <= run_sec_nxt;
      set_min_r <= set_min_nxt;
      set_sec_r <= set_sec_nxt;
      key_el_r  <= key_el_nxt;
      sec_el_r  <= sec_el_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/minute_second_clock_with_set_mode_core.sv
// Top level of the mm:ss clock core with keypad time-set mode.
//
// Each input request is one millisecond tick with a 10-bit keypad ladder
// sample; each tick yields exactly one result request with the mode, the
// running clock, the edit values, the decoded key and a start pulse. The
// core takes one tick per clock cycle: a tick is captured in an input
// register, its key decode, mode update and second advance are done by
// short compare/increment logic in the engine, and the result lands in an
// output register once that register is free. The input register refills
// while the output register still holds an untaken result, so throughput
// stays at one tick per cycle as long as the sink keeps taking results.
// The two interval registers (key sample spacing and milliseconds per
// clock second) reset to 150 and 1000 and should be written only while no
// tick is in flight; the write port is always ready.
`default_nettype none

module minute_second_clock_with_set_mode_core (
  input  wire logic clk,
  input  wire logic rst_n,
  msc_in_if.sink    in_s,
  msc_out_if.source out_m,
  msc_cfg_if.sink   cfg_s
);

  // input stage
  logic            stage_v_r, stage_v_nxt;
  msc_pkg::level_t stage_level_r;
  // output stage
  logic             out_v_r, out_v_nxt;
  msc_pkg::result_t out_r;

  msc_pkg::cfg_t    cfg;
  msc_pkg::result_t res;
  logic             in_fire;
  logic             advance;   // stage item goes through the engine this cycle

  msc_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  msc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .level (stage_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance    = stage_v_r && (!out_v_r || out_m.ready);
  assign in_s.ready = !stage_v_r || advance;
  assign in_fire    = in_s.valid && in_s.ready;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_fire)      stage_v_nxt = 1'b1;
    else if (advance) stage_v_nxt = 1'b0;

    out_v_nxt = out_v_r;
    if (advance)          out_v_nxt = 1'b1;
    else if (out_m.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) stage_level_r <= in_s.key_level;
    if (advance) out_r         <= res;
  end

  assign out_m.valid         = out_v_r;
  assign out_m.mode          = out_r.mode;
  assign out_m.clock_minutes = out_r.clock_minutes;
  assign out_m.clock_seconds = out_r.clock_seconds;
  assign out_m.edit_minutes  = out_r.edit_minutes;
  assign out_m.edit_seconds  = out_r.edit_seconds;
  assign out_m.key_code      = out_r.key_code;
  assign out_m.start_request = out_r.start_request;

  // a start pulse only comes from an up key seen in run mode
  a_start_is_up_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.start_request |->
      out_r.key_code == msc_pkg::KEY_UP && out_r.mode == msc_pkg::MODE_RUN)
    else $error("start pulse without up key in run mode");

  // a held input tick is not dropped while the engine is blocked
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !advance |=> stage_v_r && $stable(stage_level_r))
    else $error("input stage lost a tick");

  // every tick through the engine shows up as a result next cycle
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed tick produced no result");

  // running clock stays in range
  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.clock_seconds <= msc_pkg::TVAL_MAX &&
                out_r.clock_minutes <= msc_pkg::TVAL_MAX)
    else $error("clock value out of range");

endmodule

`default_nettype wire

### bench/minute_second_clock_with_set_mode_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the mm:ss clock core with keypad time-set mode.

module minute_second_clock_with_set_mode_core_test;
  import msc_pkg::*;

  // Longest legal quiet stretch is the long sink hold in test_backpressure; allow plenty over that.
  localparam int STALL_LIMIT = 2000;
  // Index outside the register map: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  msc_in_if  in_ch ();
  msc_out_if out_ch ();
  msc_cfg_if cfg_ch ();

  minute_second_clock_with_set_mode_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock model: mirrors the core's state, advanced once per accepted tick
  // ---------------------------------------------------------------------------
  mode_t     cur_mode;
  tval_t     run_min, run_sec;     // running clock
  tval_t     edit_min, edit_sec;   // values under edit
  count_t    key_ms, sec_ms;       // saturating millisecond counters
  interval_t key_iv, sec_iv;       // mirrored interval registers

  result_t     expected_readings[$];   // one pending reading per accepted tick
  int          failures = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned settings_used = 0;
  int unsigned key_seen [6];

  // Pacing controls shared with the sink process
  bit          steady = 1'b0;        // no gaps on either side
  int unsigned sink_hold_len = 0;    // request for one long sink hold-off

  function automatic key_t classify_level(input level_t lvl);
    if (lvl > LEVEL_NONE_ABOVE)   return KEY_NONE;
    if (lvl < LEVEL_RIGHT_BELOW)  return KEY_RIGHT;
    if (lvl < LEVEL_UP_BELOW)     return KEY_UP;
    if (lvl < LEVEL_DOWN_BELOW)   return KEY_DOWN;
    if (lvl < LEVEL_LEFT_BELOW)   return KEY_LEFT;
    if (lvl < LEVEL_SELECT_BELOW) return KEY_SELECT;
    return KEY_NONE;
  endfunction

  function automatic tval_t bump_up(input tval_t v);
    return (v < TVAL_MAX) ? tval_t'(v + 1'b1) : tval_t'(0);
  endfunction

  function automatic tval_t bump_down(input tval_t v);
    return (v != 0 && v <= TVAL_MAX) ? tval_t'(v - 1'b1) : TVAL_MAX;
  endfunction

  // One millisecond tick: key sampling, mode handling, then second advance.
  function automatic result_t predict_tick(input level_t lvl);
    key_t    k;
    logic    start;
    result_t r;
    k     = KEY_NONE;
    start = 1'b0;

    if (key_ms != '1) key_ms = count_t'(key_ms + 1'b1);
    if (key_ms >= key_iv) begin
      k = classify_level(lvl);
      if (k != KEY_NONE) key_ms = '0;   // accepted key restarts the lockout
    end

    case (cur_mode)
      MODE_MIN: begin
        if (k == KEY_UP)            edit_min = bump_up(edit_min);
        else if (k == KEY_DOWN)     edit_min = bump_down(edit_min);
        else if (k == KEY_RIGHT)    cur_mode = MODE_SEC;
        else if (k == KEY_SELECT) begin
          cur_mode = MODE_RUN;
          run_min  = edit_min;
          run_sec  = edit_sec;
        end
      end
      MODE_SEC: begin
        if (k == KEY_UP)            edit_sec = bump_up(edit_sec);
        else if (k == KEY_DOWN)     edit_sec = bump_down(edit_sec);
        else if (k == KEY_LEFT)     cur_mode = MODE_MIN;
        else if (k == KEY_SELECT) begin
          cur_mode = MODE_RUN;
          run_min  = edit_min;
          run_sec  = edit_sec;
        end
      end
      default: begin
        cur_mode = MODE_RUN;
        if (k == KEY_SELECT) begin
          cur_mode = MODE_MIN;
          edit_min = run_min;
          edit_sec = run_sec;
        end else if (k == KEY_UP) begin
          start = 1'b1;
        end
      end
    endcase

    if (sec_ms != '1) sec_ms = count_t'(sec_ms + 1'b1);
    if (sec_ms >= sec_iv) begin
      if (run_sec < TVAL_MAX) begin
        run_sec = tval_t'(run_sec + 1'b1);
      end else begin
        run_sec = '0;
        run_min = bump_up(run_min);
      end
      sec_ms = '0;
    end

    r.mode          = cur_mode;
    r.clock_minutes = run_min;
    r.clock_seconds = run_sec;
    r.edit_minutes  = edit_min;
    r.edit_seconds  = edit_sec;
    r.key_code      = k;
    r.start_request = start;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random ladder sample that decodes to the given key.
  function automatic level_t level_in_band(input key_t k);
    case (k)
      KEY_RIGHT:  return level_t'($urandom_range(0, LEVEL_RIGHT_BELOW - 1));
      KEY_UP:     return level_t'($urandom_range(LEVEL_RIGHT_BELOW, LEVEL_UP_BELOW - 1));
      KEY_DOWN:   return level_t'($urandom_range(LEVEL_UP_BELOW, LEVEL_DOWN_BELOW - 1));
      KEY_LEFT:   return level_t'($urandom_range(LEVEL_DOWN_BELOW, LEVEL_LEFT_BELOW - 1));
      KEY_SELECT: return level_t'($urandom_range(LEVEL_LEFT_BELOW, LEVEL_SELECT_BELOW - 1));
      default: begin
        // both "none" bands: the gap below the top threshold and above it
        if ($urandom_range(0, 1) == 0)
          return level_t'($urandom_range(LEVEL_SELECT_BELOW, LEVEL_NONE_ABOVE));
        return level_t'($urandom_range(LEVEL_NONE_ABOVE + 1, 1023));
      end
    endcase
  endfunction

  // Offer one tick request and hold it until taken; predict on acceptance.
  task automatic send_tick(input level_t lvl);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.key_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    expected_readings.push_back(predict_tick(lvl));
    ticks_sent++;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every pending reading is back, then lets the pipe settle.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input interval_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_KEY_INTERVAL)         key_iv = val;
    else if (idx == CFG_SECOND_INTERVAL) sec_iv = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_intervals(input interval_t k, input interval_t s);
    wait_results_done();
    write_reg(CFG_KEY_INTERVAL, k);
    write_reg(CFG_SECOND_INTERVAL, s);
    settings_used++;
  endtask

  // Wait out the key lockout (with stray early presses that must be ignored),
  // then present the key so that it is sampled.
  task automatic press_key(input key_t k);
    repeat ($urandom_range(0, 1)) send_tick(level_in_band(KEY_NONE));
    while ((int'(key_ms) + 1) < int'(key_iv)) begin
      if ($urandom_range(0, 3) == 0) send_tick(level_in_band(key_t'($urandom_range(0, 5))));
      else send_tick(level_in_band(KEY_NONE));
    end
    send_tick(level_in_band(k));
  endtask

  // Select, a run of edits and field moves, then usually a commit.
  task automatic run_edit_session();
    key_t        k;
    int unsigned n;
    press_key(KEY_SELECT);
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2: k = KEY_UP;
        3, 4:    k = KEY_DOWN;
        5:       k = KEY_RIGHT;
        6:       k = KEY_LEFT;
        default: k = KEY_NONE;
      endcase
      press_key(k);
    end
    if ($urandom_range(0, 6) != 0) press_key(KEY_SELECT);   // else left dangling
    if ($urandom_range(0, 2) == 0) press_key(KEY_UP);       // start pulse if running
    repeat ($urandom_range(0, 4)) send_tick(level_in_band(KEY_NONE));
  endtask

  task automatic run_random_phase(input interval_t k, input interval_t s, input int unsigned n);
    int unsigned stop_at;
    set_intervals(k, s);
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) run_edit_session();
      else repeat ($urandom_range(1, 6)) send_tick(level_t'($urandom_range(0, 1023)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset intervals (150 ms lockout): early presses decode to nothing.
  task automatic test_idle_after_reset();
    send_tick(level_in_band(KEY_SELECT));
    send_tick(level_in_band(KEY_UP));
    send_tick(level_t'(0));
  endtask

  // Zero key interval samples every tick; walk both sides of every threshold.
  task automatic test_key_decode();
    level_t probes [14];
    probes = '{level_t'(0),
               level_t'(LEVEL_RIGHT_BELOW - 1),  LEVEL_RIGHT_BELOW,
               level_t'(LEVEL_UP_BELOW - 1),     LEVEL_UP_BELOW,
               level_t'(LEVEL_DOWN_BELOW - 1),   LEVEL_DOWN_BELOW,
               level_t'(LEVEL_LEFT_BELOW - 1),   LEVEL_LEFT_BELOW,
               level_t'(LEVEL_SELECT_BELOW - 1), LEVEL_SELECT_BELOW,
               LEVEL_NONE_ABOVE, level_t'(LEVEL_NONE_ABOVE + 1), level_t'('1)};
    set_intervals('0, '1);
    foreach (probes[i]) send_tick(probes[i]);
  endtask

  // Edit both fields through their wrap points, move between fields,
  // commit 59:59 and pulse start from run mode.
  task automatic test_edit_wrap();
    set_intervals(interval_t'(1), '1);
    press_key(KEY_SELECT);
    press_key(KEY_DOWN);
    press_key(KEY_UP);
    press_key(KEY_DOWN);
    press_key(KEY_RIGHT);
    press_key(KEY_DOWN);
    press_key(KEY_UP);
    press_key(KEY_DOWN);
    press_key(KEY_LEFT);
    press_key(KEY_RIGHT);
    press_key(KEY_SELECT);
    press_key(KEY_UP);
  endtask

  // Zero second interval: clock advances each tick, across 59:59.
  task automatic test_clock_rollover();
    set_intervals(interval_t'(1), '0);
    repeat (3) send_tick(level_in_band(KEY_NONE));
  endtask

  // A write to an unmapped index must leave both intervals alone.
  task automatic test_spare_register_index();
    wait_results_done();
    write_reg(CFG_SPARE_IDX, '1);
    press_key(KEY_SELECT);
    press_key(KEY_SELECT);
  endtask

  // Full-scale intervals: neither timer comes due in a short burst, so
  // every sample decodes to nothing and the clock holds still.
  task automatic test_full_scale_intervals();
    set_intervals('1, '1);
    steady = 1'b1;
    repeat (40) send_tick(level_t'($urandom_range(0, 1023)));
    steady = 1'b0;
  endtask

  // Sink holds off while the sender keeps offering: the core must fill and
  // stall its input, then drain without loss.
  task automatic test_backpressure();
    set_intervals(interval_t'(2), interval_t'(5));
    steady        = 1'b1;
    sink_hold_len = 300;
    repeat (40) send_tick(level_t'($urandom_range(0, 1023)));
    steady = 1'b0;
    wait_results_done();
  endtask

  task automatic test_random_sessions();
    run_random_phase(interval_t'(1), interval_t'(1), 115);
    run_random_phase(interval_t'(3), interval_t'(25), 115);
    run_random_phase('0, interval_t'(7), 115);
    run_random_phase(interval_t'($urandom_range(1, 10)), interval_t'($urandom_range(1, 400)), 115);
    run_random_phase(interval_t'(6), '1, 115);
    run_random_phase(interval_t'(2), interval_t'($urandom_range(0, 65535)), 105);
  endtask

  // ---------------------------------------------------------------------------
  // Sink pacing: random stalls, one long hold-off on request, none when steady
  // ---------------------------------------------------------------------------
  initial begin : sink_pacer
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
        out_ch.ready <= 1'b1;
      end else if (steady) begin
        stall = 0;
        out_ch.ready <= 1'b1;
      end else if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: each taken result request against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
               $time, name, results_seen, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual mode %0d clock %0d:%0d",
                 $time, out_ch.mode, out_ch.clock_minutes, out_ch.clock_seconds);
        failures++;
      end else begin
        want = expected_readings.pop_front();
        compare_field("mode",          want.mode,          out_ch.mode);
        compare_field("clock_minutes", want.clock_minutes, out_ch.clock_minutes);
        compare_field("clock_seconds", want.clock_seconds, out_ch.clock_seconds);
        compare_field("edit_minutes",  want.edit_minutes,  out_ch.edit_minutes);
        compare_field("edit_seconds",  want.edit_seconds,  out_ch.edit_seconds);
        compare_field("key_code",      want.key_code,      out_ch.key_code);
        compare_field("start_request", want.start_request, out_ch.start_request);
        if (out_ch.key_code < 6) key_seen[out_ch.key_code]++;
        if (out_ch.start_request) starts_seen++;
        results_seen++;
      end
    end
  end

  // Watchdog: too long without any request moving on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results pending",
                 $time, quiet, expected_readings.size());
        $display("minute_second_clock_with_set_mode_core_test: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    foreach (key_seen[i]) key_seen[i] = 0;
    cur_mode = MODE_RUN;
    run_min  = '0;
    run_sec  = '0;
    edit_min = '0;
    edit_sec = '0;
    key_ms   = '0;
    sec_ms   = '0;
    key_iv   = KEY_INTERVAL_RST;
    sec_iv   = SECOND_INTERVAL_RST;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.key_level <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_key_decode();
    test_edit_wrap();
    test_clock_rollover();
    test_spare_register_index();
    test_full_scale_intervals();
    test_backpressure();
    test_random_sessions();

    wait_results_done();
    repeat (6) @(posedge clk);

    $display("Covered %0d ticks over %0d interval settings incl. zero and full scale, %0d results",
             ticks_sent, settings_used, results_seen);
    $display("Keys right/up/down/left/select %0d/%0d/%0d/%0d/%0d, start pulses %0d",
             key_seen[KEY_RIGHT], key_seen[KEY_UP], key_seen[KEY_DOWN],
             key_seen[KEY_LEFT], key_seen[KEY_SELECT], starts_seen);
    if (failures == 0) begin
      $display("minute_second_clock_with_set_mode_core_test: PASS");
    end else begin
      $display("minute_second_clock_with_set_mode_core_test: FAIL");
    end
    $finish;
  end

endmodule
